FILE: rtl/core/prc_pkg.sv
// shared types, widths and constants of the point rotation pipeline
// no dependencies; used by the channel interfaces, the cordic stage and the top level
`default_nettype none

package prc_pkg;

   localparam int COORD_W             = 24;
   localparam int ANGLE_W             = 17;
   localparam int DIFF_W              = COORD_W + 1;
   localparam int ROTATION_ITERATIONS = 16;
   localparam int ATAN_ENTRIES        = 24;
   localparam int CORDIC_STAGES       = (ROTATION_ITERATIONS > ATAN_ENTRIES) ?
                                        ATAN_ENTRIES : ROTATION_ITERATIONS;

   // angle units are 1/128 degree
   localparam int TURN_UNITS    = 46080;
   localparam int QUARTER_UNITS = 11520;
   localparam int EIGHTH_UNITS  = 5760;
   localparam int ANGLE_SHIFT   = 15;
   localparam int WRAP_W        = 16;
   localparam int RES_W         = 14;
   localparam int Z_W           = 30;

   // trig values in q2.30
   localparam int TRIG_W       = 32;
   localparam int TRIG_FRAC    = 30;
   localparam int CORDIC_GAIN  = 652032874;
   localparam int TRIG_ONE     = 1 << TRIG_FRAC;

   localparam int PROD_W  = DIFF_W + TRIG_W;
   localparam int SUM_W   = PROD_W + 1;
   localparam int ROUND_W = SUM_W - TRIG_FRAC;
   localparam int OUT_W   = ROUND_W + 1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic signed [TRIG_W-1:0]  trig_type;

   typedef struct packed {
      diff_type   dx;
      diff_type   dy;
      coord_type  cx;
      coord_type  cy;
      logic [1:0] quad;
   } prc_side_type;

   // atan(2^-i) in degrees * 2^22
   function automatic logic signed [Z_W-1:0] atan_value(input int idx);
      logic signed [Z_W-1:0] val;
      unique case (idx)
         0:  val = Z_W'(188743680);
         1:  val = Z_W'(111421900);
         2:  val = Z_W'(58872272);
         3:  val = Z_W'(29884485);
         4:  val = Z_W'(15000234);
         5:  val = Z_W'(7507429);
         6:  val = Z_W'(3754631);
         7:  val = Z_W'(1877430);
         8:  val = Z_W'(938729);
         9:  val = Z_W'(469366);
         10: val = Z_W'(234683);
         11: val = Z_W'(117342);
         12: val = Z_W'(58671);
         13: val = Z_W'(29335);
         14: val = Z_W'(14668);
         15: val = Z_W'(7334);
         16: val = Z_W'(3667);
         17: val = Z_W'(1833);
         18: val = Z_W'(917);
         19: val = Z_W'(458);
         20: val = Z_W'(229);
         21: val = Z_W'(115);
         22: val = Z_W'(57);
         23: val = Z_W'(29);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/prc_if.sv
// valid/ready channel interfaces for rotation requests and responses
// depends on prc_pkg for field widths
`default_nettype none

interface prc_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [prc_pkg::COORD_W-1:0]  point_x;
   logic signed [prc_pkg::COORD_W-1:0]  point_y;
   logic signed [prc_pkg::COORD_W-1:0]  pivot_x;
   logic signed [prc_pkg::COORD_W-1:0]  pivot_y;
   logic signed [prc_pkg::ANGLE_W-1:0]  angle;

   modport source (output valid, point_x, point_y, pivot_x, pivot_y, angle, input ready);
   modport sink   (input valid, point_x, point_y, pivot_x, pivot_y, angle, output ready);
endinterface

interface prc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [prc_pkg::COORD_W-1:0]  rotated_x;
   logic signed [prc_pkg::COORD_W-1:0]  rotated_y;
   logic                                overflow;

   modport source (output valid, rotated_x, rotated_y, overflow, input ready);
   modport sink   (input valid, rotated_x, rotated_y, overflow, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/prc_cordic.sv
// pipelined cordic in rotation mode, one micro-rotation per register stage
// depends on prc_pkg for widths and the arctangent table
`default_nettype none

module prc_cordic (
   input  logic                               clock,
   input  logic                               enable,
   input  logic signed [prc_pkg::RES_W-1:0]   residual,
   output logic signed [prc_pkg::TRIG_W-1:0]  cos_out,
   output logic signed [prc_pkg::TRIG_W-1:0]  sin_out
);
   import prc_pkg::*;

   trig_type               x_src  [CORDIC_STAGES];
   trig_type               y_src  [CORDIC_STAGES];
   logic signed [Z_W-1:0]  z_src  [CORDIC_STAGES];
   logic                   zero_src [CORDIC_STAGES];

   trig_type               x_in   [CORDIC_STAGES];
   trig_type               y_in   [CORDIC_STAGES];
   logic signed [Z_W-1:0]  z_in   [CORDIC_STAGES];

   trig_type               x_ff   [CORDIC_STAGES];
   trig_type               y_ff   [CORDIC_STAGES];
   logic signed [Z_W-1:0]  z_ff   [CORDIC_STAGES];
   logic                   zero_ff [CORDIC_STAGES];

   always_comb begin
      x_src[0]    = TRIG_W'(CORDIC_GAIN);
      y_src[0]    = '0;
      z_src[0]    = {{(Z_W-RES_W-ANGLE_SHIFT){residual[RES_W-1]}}, residual,
                     {ANGLE_SHIFT{1'b0}}};
      zero_src[0] = (residual == '0);
      for (int i = 1; i < CORDIC_STAGES; i++) begin
         x_src[i]    = x_ff[i-1];
         y_src[i]    = y_ff[i-1];
         z_src[i]    = z_ff[i-1];
         zero_src[i] = zero_ff[i-1];
      end
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         // rotate toward the remaining angle
         if (!z_src[i][Z_W-1]) begin
            x_in[i] = x_src[i] - (y_src[i] >>> i);
            y_in[i] = y_src[i] + (x_src[i] >>> i);
            z_in[i] = z_src[i] - atan_value(i);
         end else begin
            x_in[i] = x_src[i] + (y_src[i] >>> i);
            y_in[i] = y_src[i] - (x_src[i] >>> i);
            z_in[i] = z_src[i] + atan_value(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < CORDIC_STAGES; i++) begin
            x_ff[i]    <= x_in[i];
            y_ff[i]    <= y_in[i];
            z_ff[i]    <= z_in[i];
            zero_ff[i] <= zero_src[i];
         end
      end
   end

   // zero residual gives exact unit cosine
   assign cos_out = zero_ff[CORDIC_STAGES-1] ? TRIG_W'(TRIG_ONE) : x_ff[CORDIC_STAGES-1];
   assign sin_out = zero_ff[CORDIC_STAGES-1] ? '0 : y_ff[CORDIC_STAGES-1];

endmodule

`default_nettype wire

FILE: rtl/core/point_rotate_about_center_top.sv
// point rotation about a center: throughput one request per cycle while the pipeline
// is not held by a waiting response
// depth is set by the cordic micro-rotation stages plus wrap, quadrant, multiply, sum, round
// the whole pipeline holds while a response waits and the sink is not ready
// reset (synchronous, active high) clears all stage valid bits; data registers are not reset
// depends on prc_pkg, prc_if and prc_cordic
`default_nettype none

module point_rotate_about_center_top (
   input  logic     clock,
   input  logic     reset,
   prc_req_if.sink  req_chan,
   prc_rsp_if.source rsp_chan
);
   import prc_pkg::*;

   localparam int PIPE_DEPTH = CORDIC_STAGES + 5;
   localparam int AW         = ANGLE_W + 1;

   // wide angle constants for the wrap compare
   localparam logic signed [AW-1:0] TURN_S     = AW'(TURN_UNITS);
   localparam logic signed [AW-1:0] TWO_TURN_S = AW'(2 * TURN_UNITS);
   localparam logic signed [AW-1:0] NEG_TURN_S = AW'(-TURN_UNITS);

   // residual sits within one eighth turn of a quadrant center
   localparam logic [WRAP_W-1:0] Q1_EDGE = WRAP_W'(EIGHTH_UNITS);
   localparam logic [WRAP_W-1:0] Q2_EDGE = WRAP_W'(EIGHTH_UNITS + QUARTER_UNITS);
   localparam logic [WRAP_W-1:0] Q3_EDGE = WRAP_W'(EIGHTH_UNITS + 2 * QUARTER_UNITS);
   localparam logic [WRAP_W-1:0] Q4_EDGE = WRAP_W'(EIGHTH_UNITS + 3 * QUARTER_UNITS);

   localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(TRIG_ONE >> 1);
   localparam logic signed [OUT_W-1:0] SAT_MAX    = OUT_W'((1 << (COORD_W - 1)) - 1);
   localparam logic signed [OUT_W-1:0] SAT_MIN    = OUT_W'(-(1 << (COORD_W - 1)));

   // one global advance: every stage moves when the response slot frees up
   logic                    enable;
   logic [PIPE_DEPTH-1:0]   valid_ff;
   logic [PIPE_DEPTH-1:0]   valid_in;

   // stage 1: angle wrap and offsets
   logic signed [AW-1:0]    angle_ext;
   logic signed [AW-1:0]    wrap_full;
   logic [WRAP_W-1:0]       wrap_in;
   logic [WRAP_W-1:0]       wrap_ff;
   prc_side_type            side1_in;
   prc_side_type            side1_ff;

   // stage 2: quadrant split
   logic [1:0]              quad_in;
   logic signed [WRAP_W:0]  res_full;
   logic signed [RES_W-1:0] res_in;
   logic signed [RES_W-1:0] res_ff;
   prc_side_type            side2_in;
   prc_side_type            side2_ff;

   // side data riding alongside the cordic stages
   prc_side_type            side_pipe_ff [CORDIC_STAGES];

   // cordic output and quadrant fold
   trig_type                cos_raw;
   trig_type                sin_raw;
   trig_type                cos_sel;
   trig_type                sin_sel;
   prc_side_type            side_last;

   // product stage
   logic signed [PROD_W-1:0] prod_xc_in, prod_ys_in, prod_xs_in, prod_yc_in;
   logic signed [PROD_W-1:0] prod_xc_ff, prod_ys_ff, prod_xs_ff, prod_yc_ff;
   coord_type                cxp_ff, cyp_ff;

   // sum stage, rounding constant folded in
   logic signed [SUM_W-1:0]  sum_x_in, sum_y_in;
   logic signed [SUM_W-1:0]  sum_x_ff, sum_y_ff;
   coord_type                cxs_ff, cys_ff;

   // output stage: rescale, add center back, saturate
   logic signed [OUT_W-1:0]  full_x, full_y;
   coord_type                rot_x_in, rot_y_in;
   logic                     ovf_x, ovf_y;
   coord_type                rot_x_ff, rot_y_ff;
   logic                     ovf_ff;

   assign enable         = !valid_ff[PIPE_DEPTH-1] || rsp_chan.ready;
   assign req_chan.ready = enable;
   assign valid_in       = {valid_ff[PIPE_DEPTH-2:0], req_chan.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   // angle wrap into one turn
   always_comb begin
      angle_ext = AW'(req_chan.angle);
      if (angle_ext < NEG_TURN_S) begin
         wrap_full = angle_ext + TWO_TURN_S;
      end else if (angle_ext < 0) begin
         wrap_full = angle_ext + TURN_S;
      end else if (angle_ext >= TURN_S) begin
         wrap_full = angle_ext - TURN_S;
      end else begin
         wrap_full = angle_ext;
      end
      wrap_in = wrap_full[WRAP_W-1:0];

      side1_in.dx   = DIFF_W'(req_chan.point_x) - DIFF_W'(req_chan.pivot_x);
      side1_in.dy   = DIFF_W'(req_chan.point_y) - DIFF_W'(req_chan.pivot_y);
      side1_in.cx   = req_chan.pivot_x;
      side1_in.cy   = req_chan.pivot_y;
      side1_in.quad = '0;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         wrap_ff  <= wrap_in;
         side1_ff <= side1_in;
      end
   end

   // nearest quadrant and signed residual; a full turn folds back to quadrant zero
   always_comb begin
      if (wrap_ff >= Q4_EDGE) begin
         quad_in  = 2'd0;
         res_full = $signed({1'b0, wrap_ff}) - (WRAP_W+1)'(4 * QUARTER_UNITS);
      end else if (wrap_ff >= Q3_EDGE) begin
         quad_in  = 2'd3;
         res_full = $signed({1'b0, wrap_ff}) - (WRAP_W+1)'(3 * QUARTER_UNITS);
      end else if (wrap_ff >= Q2_EDGE) begin
         quad_in  = 2'd2;
         res_full = $signed({1'b0, wrap_ff}) - (WRAP_W+1)'(2 * QUARTER_UNITS);
      end else if (wrap_ff >= Q1_EDGE) begin
         quad_in  = 2'd1;
         res_full = $signed({1'b0, wrap_ff}) - (WRAP_W+1)'(QUARTER_UNITS);
      end else begin
         quad_in  = 2'd0;
         res_full = $signed({1'b0, wrap_ff});
      end
      res_in = res_full[RES_W-1:0];

      side2_in      = side1_ff;
      side2_in.quad = quad_in;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         res_ff   <= res_in;
         side2_ff <= side2_in;
      end
   end

   prc_cordic u_cordic (
      .clock    (clock),
      .enable   (enable),
      .residual (res_ff),
      .cos_out  (cos_raw),
      .sin_out  (sin_raw)
   );

   always_ff @(posedge clock) begin
      if (enable) begin
         side_pipe_ff[0] <= side2_ff;
         for (int i = 1; i < CORDIC_STAGES; i++) begin
            side_pipe_ff[i] <= side_pipe_ff[i-1];
         end
      end
   end

   assign side_last = side_pipe_ff[CORDIC_STAGES-1];

   // quarter-turn fold of cosine and sine
   always_comb begin
      case (side_last.quad)
         2'd1: begin
            cos_sel = -sin_raw;
            sin_sel = cos_raw;
         end
         2'd2: begin
            cos_sel = -cos_raw;
            sin_sel = -sin_raw;
         end
         2'd3: begin
            cos_sel = sin_raw;
            sin_sel = -cos_raw;
         end
         default: begin
            cos_sel = cos_raw;
            sin_sel = sin_raw;
         end
      endcase
      prod_xc_in = side_last.dx * cos_sel;
      prod_ys_in = side_last.dy * sin_sel;
      prod_xs_in = side_last.dx * sin_sel;
      prod_yc_in = side_last.dy * cos_sel;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_xc_ff <= prod_xc_in;
         prod_ys_ff <= prod_ys_in;
         prod_xs_ff <= prod_xs_in;
         prod_yc_ff <= prod_yc_in;
         cxp_ff     <= side_last.cx;
         cyp_ff     <= side_last.cy;
      end
   end

   assign sum_x_in = SUM_W'(prod_xc_ff) - SUM_W'(prod_ys_ff) + ROUND_HALF;
   assign sum_y_in = SUM_W'(prod_xs_ff) + SUM_W'(prod_yc_ff) + ROUND_HALF;

   always_ff @(posedge clock) begin
      if (enable) begin
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
         cxs_ff   <= cxp_ff;
         cys_ff   <= cyp_ff;
      end
   end

   // drop the trig fraction bits, add the center, clamp to coordinate range
   always_comb begin
      full_x = OUT_W'($signed(sum_x_ff[SUM_W-1:TRIG_FRAC])) + OUT_W'(cxs_ff);
      full_y = OUT_W'($signed(sum_y_ff[SUM_W-1:TRIG_FRAC])) + OUT_W'(cys_ff);
      ovf_x  = 1'b1;
      ovf_y  = 1'b1;
      if (full_x > SAT_MAX) begin
         rot_x_in = SAT_MAX[COORD_W-1:0];
      end else if (full_x < SAT_MIN) begin
         rot_x_in = SAT_MIN[COORD_W-1:0];
      end else begin
         rot_x_in = full_x[COORD_W-1:0];
         ovf_x    = 1'b0;
      end
      if (full_y > SAT_MAX) begin
         rot_y_in = SAT_MAX[COORD_W-1:0];
      end else if (full_y < SAT_MIN) begin
         rot_y_in = SAT_MIN[COORD_W-1:0];
      end else begin
         rot_y_in = full_y[COORD_W-1:0];
         ovf_y    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rot_x_ff <= rot_x_in;
         rot_y_ff <= rot_y_in;
         ovf_ff   <= ovf_x || ovf_y;
      end
   end

   assign rsp_chan.valid     = valid_ff[PIPE_DEPTH-1];
   assign rsp_chan.rotated_x = rot_x_ff;
   assign rsp_chan.rotated_y = rot_y_ff;
   assign rsp_chan.overflow  = ovf_ff;

endmodule

`default_nettype wire

FILE: rtl/core/prc_checker.sv
// port-level assertions for the point rotation top level, attached by bind
// depends on prc_pkg and point_rotate_about_center_top
`default_nettype none

module prc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [prc_pkg::COORD_W-1:0] rotated_x,
   input logic signed [prc_pkg::COORD_W-1:0] rotated_y,
   input logic                               overflow
);
   import prc_pkg::*;

   localparam logic signed [COORD_W-1:0] LIM_MAX = COORD_W'((1 << (COORD_W - 1)) - 1);
   localparam logic signed [COORD_W-1:0] LIM_MIN = COORD_W'(-(1 << (COORD_W - 1)));

   // no response straight out of reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a held response keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rotated_x) && $stable(rotated_y)
         && $stable(overflow))
      else $error("stalled response changed");

   // the pipeline takes a request whenever the response slot is free or draining
   assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow response slot");

   // an overflow flag only comes with a clamped coordinate
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && overflow |-> rotated_x == LIM_MAX || rotated_x == LIM_MIN
         || rotated_y == LIM_MAX || rotated_y == LIM_MIN)
      else $error("overflow without clamped coordinate");

   // after a stalled request, request ready returns once the response sink is ready
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> !rsp_ready || !$past(rsp_valid) || req_ready)
      else $error("request ready stuck while response drains");

endmodule

bind point_rotate_about_center_top prc_checker u_prc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rotated_x (rsp_chan.rotated_x),
   .rotated_y (rsp_chan.rotated_y),
   .overflow  (rsp_chan.overflow)
);

`default_nettype wire
